### sv/gpvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpvt_pkg
// shared types, field offsets and status codes of the pvt message parser
// ----------------------------------------------------------------------------
package gpvt_pkg;

   // default payload length of a pvt message
   localparam int unsigned PAYLOAD_BYTES_DEF = 92;

   // positions ahead of the payload (two length bytes)
   localparam int unsigned HDR_BYTES = 2;

   // payload offsets
   localparam int unsigned OFS_DATE   = 4;
   localparam int unsigned DATE_BYTES = 7;
   localparam int unsigned OFS_VALID  = 11;
   localparam int unsigned OFS_FLAGS  = 21;
   localparam int unsigned OFS_SATS   = 23;
   localparam int unsigned OFS_POS    = 24;
   localparam int unsigned POS_WORDS  = 4;
   localparam int unsigned POS_BYTES  = 4 * POS_WORDS;

   // date and time limits
   localparam logic [7:0] MONTH_MAX  = 8'd12;
   localparam logic [7:0] DAY_MAX    = 8'd31;
   localparam logic [7:0] HOUR_MAX   = 8'd23;
   localparam logic [7:0] MINUTE_MAX = 8'd59;
   localparam logic [7:0] SECOND_MAX = 8'd60;

   // status codes
   localparam logic [3:0] ST_OK       = 4'd0;
   localparam logic [3:0] ST_LENGTH   = 4'd1;
   localparam logic [3:0] ST_MONTH    = 4'd2;
   localparam logic [3:0] ST_DAY      = 4'd3;
   localparam logic [3:0] ST_HOUR     = 4'd4;
   localparam logic [3:0] ST_MINUTE   = 4'd5;
   localparam logic [3:0] ST_SECOND   = 4'd6;
   localparam logic [3:0] ST_VALID    = 4'd7;
   localparam logic [3:0] ST_FIX      = 4'd8;
   localparam logic [3:0] ST_CHECKSUM = 4'd9;

   // register indexes
   localparam logic [1:0] REG_CLASS     = 2'd0;
   localparam logic [1:0] REG_ID        = 2'd1;
   localparam logic [1:0] REG_VALID_MSK = 2'd2;
   localparam logic [1:0] REG_FIX_MSK   = 2'd3;

   // register reset values
   localparam logic [7:0] CLASS_RST     = 8'd1;
   localparam logic [7:0] ID_RST        = 8'd7;
   localparam logic [7:0] VALID_MSK_RST = 8'd15;
   localparam logic [7:0] FIX_MSK_RST   = 8'd0;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic        [3:0]  status;
      logic        [15:0] year;
      logic        [7:0]  month;
      logic        [7:0]  day;
      logic        [7:0]  hour;
      logic        [7:0]  minute;
      logic        [7:0]  second;
      logic        [7:0]  satellites;
      logic signed [31:0] longitude;
      logic signed [31:0] latitude;
      logic signed [31:0] height_ellipsoid;
      logic signed [31:0] height_sea_level;
   } rsp_type;

   // captured message fields and running checksum
   typedef struct packed {
      logic [15:0] year;
      logic [7:0]  month;
      logic [7:0]  day;
      logic [7:0]  hour;
      logic [7:0]  minute;
      logic [7:0]  second;
      logic [7:0]  valid_byte;
      logic [7:0]  flags_byte;
      logic [7:0]  satellites;
      logic [31:0] longitude;
      logic [31:0] latitude;
      logic [31:0] height_ellipsoid;
      logic [31:0] height_sea_level;
      logic [7:0]  sum_a;
      logic [7:0]  sum_b;
      logic [7:0]  rx_sum_a;
   } cap_type;

   // per-word events from the framer
   typedef struct packed {
      logic       len_err;
      logic       done;
      logic [7:0] ck_b;
   } evt_type;

   // configuration seen by the framer and checker
   typedef struct packed {
      logic [7:0] msg_class;
      logic [7:0] msg_id;
      logic [7:0] valid_mask;
      logic [7:0] fix_mask;
   } cfg_type;

endpackage

### sv/gnss_pvt_message_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_pvt_message_parser_core
// byte-serial parser for one gnss position-velocity-time message
// ----------------------------------------------------------------------------
// a result is pushed into the result buffer on the accepted word that ends it
//   (high length byte on a length error, second checksum byte otherwise)
// throughput: one word per cycle while req_stall is low
// req_stall rises only while both result buffer entries wait downstream
// reset (synchronous, active high): framer idle, result buffer empty,
//   registers back to class 1, id 7, valid mask 15, fix mask 0
// ----------------------------------------------------------------------------
module gnss_pvt_message_parser_core #(
   parameter int unsigned PAYLOAD_BYTES = gpvt_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // input word channel
   input  logic              req_valid,
   output logic              req_stall,
   input  gpvt_pkg::req_type req_payload,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gpvt_pkg::rsp_type rsp_payload,
   // configuration write port
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_write_data
);

   // configuration registers
   logic [7:0] class_ff, class_in;
   logic [7:0] id_ff, id_in;
   logic [7:0] valid_msk_ff, valid_msk_in;
   logic [7:0] fix_msk_ff, fix_msk_in;

   gpvt_pkg::cfg_type cfg;
   gpvt_pkg::cap_type cap;
   gpvt_pkg::evt_type evt;
   gpvt_pkg::rsp_type result;
   logic              in_accept;
   logic              push;
   logic              buf_full;

   always_comb begin
      class_in     = class_ff;
      id_in        = id_ff;
      valid_msk_in = valid_msk_ff;
      fix_msk_in   = fix_msk_ff;
      if (csr_write_enable) begin
         case (csr_index)
            gpvt_pkg::REG_CLASS:     class_in     = csr_write_data;
            gpvt_pkg::REG_ID:        id_in        = csr_write_data;
            gpvt_pkg::REG_VALID_MSK: valid_msk_in = csr_write_data;
            gpvt_pkg::REG_FIX_MSK:   fix_msk_in   = csr_write_data;
            default:                 class_in     = class_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff     <= gpvt_pkg::CLASS_RST;
         id_ff        <= gpvt_pkg::ID_RST;
         valid_msk_ff <= gpvt_pkg::VALID_MSK_RST;
         fix_msk_ff   <= gpvt_pkg::FIX_MSK_RST;
      end else begin
         class_ff     <= class_in;
         id_ff        <= id_in;
         valid_msk_ff <= valid_msk_in;
         fix_msk_ff   <= fix_msk_in;
      end
   end

   assign cfg.msg_class  = class_ff;
   assign cfg.msg_id     = id_ff;
   assign cfg.valid_mask = valid_msk_ff;
   assign cfg.fix_mask   = fix_msk_ff;

   // stall comes from buffer occupancy only, never from rsp_stall directly
   assign req_stall = buf_full;
   assign in_accept = req_valid && !req_stall;

   // framer: position counter, checksum and field capture
   gpvt_frame #(
      .PAYLOAD_BYTES(PAYLOAD_BYTES)
   ) u_frame (
      .clock    (clock),
      .reset    (reset),
      .in_accept(in_accept),
      .in_word  (req_payload),
      .cfg      (cfg),
      .cap      (cap),
      .evt      (evt)
   );

   // checks on the captured fields, combined with the second checksum byte
   gpvt_check u_check (
      .cap   (cap),
      .evt   (evt),
      .cfg   (cfg),
      .push  (push),
      .result(result)
   );

   // result register plus skid entry
   gpvt_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_word  (result),
      .full       (buf_full),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   // results only come from accepted words
   a_push_on_accept: assert property (@(posedge clock) disable iff (reset)
      push |-> in_accept)
      else $error("result produced without an accepted word");

   // a length error result carries nothing but its status
   a_len_err_clean: assert property (@(posedge clock) disable iff (reset)
      evt.len_err |-> result.status == gpvt_pkg::ST_LENGTH && result.year == 16'd0)
      else $error("length error result not cleared");

   // stall means results are waiting
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("stalled with no result waiting");

endmodule

### sv/gpvt_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpvt_frame
// byte position tracking, fletcher-8 checksum and payload field capture
// ----------------------------------------------------------------------------
module gpvt_frame #(
   parameter int unsigned PAYLOAD_BYTES = gpvt_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_accept,
   input  gpvt_pkg::req_type in_word,
   input  gpvt_pkg::cfg_type cfg,
   output gpvt_pkg::cap_type cap,
   output gpvt_pkg::evt_type evt
);

   localparam int unsigned PosW = $clog2(PAYLOAD_BYTES + 4);
   localparam int unsigned DateFirst = gpvt_pkg::HDR_BYTES + gpvt_pkg::OFS_DATE;
   localparam int unsigned PosFirst  = gpvt_pkg::HDR_BYTES + gpvt_pkg::OFS_POS;

   logic [PosW-1:0] pos_ff, pos_in;
   logic [7:0]      sum_a_ff, sum_a_in;
   logic [7:0]      sum_b_ff, sum_b_in;
   logic [7:0]      len_lo_ff, len_lo_in;
   logic [7:0]      rx_sum_a_ff, rx_sum_a_in;
   logic [7:0]      date_ff [gpvt_pkg::DATE_BYTES];
   logic [7:0]      date_in [gpvt_pkg::DATE_BYTES];
   logic [7:0]      pos_byte_ff [gpvt_pkg::POS_BYTES];
   logic [7:0]      pos_byte_in [gpvt_pkg::POS_BYTES];
   logic [7:0]      valid_ff, valid_in;
   logic [7:0]      flags_ff, flags_in;
   logic [7:0]      sats_ff, sats_in;

   logic [7:0] b;
   logic [7:0] add_a, add_b;
   logic [7:0] seed_a2, seed_b2, seed_a3, seed_b3;
   logic       capture_en;

   assign b = in_word.data_byte;

   // running sum step
   assign add_a = sum_a_ff + b;
   assign add_b = sum_b_ff + add_a;

   // seeded sum over class, id and the low length byte
   assign seed_a2 = cfg.msg_class + cfg.msg_id;
   assign seed_b2 = cfg.msg_class + seed_a2;
   assign seed_a3 = seed_a2 + b;
   assign seed_b3 = seed_b2 + seed_a3;

   always_comb begin
      pos_in      = pos_ff;
      sum_a_in    = sum_a_ff;
      sum_b_in    = sum_b_ff;
      len_lo_in   = len_lo_ff;
      rx_sum_a_in = rx_sum_a_ff;
      capture_en  = 1'b0;
      evt.len_err = 1'b0;
      evt.done    = 1'b0;
      evt.ck_b    = b;
      if (in_accept) begin
         if (in_word.frame_start) begin
            pos_in    = PosW'(1);
            sum_a_in  = seed_a3;
            sum_b_in  = seed_b3;
            len_lo_in = b;
         end else if (pos_ff == '0) begin
            pos_in = pos_ff;
         end else if (pos_ff == PosW'(1)) begin
            sum_a_in = add_a;
            sum_b_in = add_b;
            if ({b, len_lo_ff} != 16'(PAYLOAD_BYTES)) begin
               pos_in      = '0;
               evt.len_err = 1'b1;
            end else begin
               pos_in = PosW'(2);
            end
         end else if (pos_ff < PosW'(PAYLOAD_BYTES + gpvt_pkg::HDR_BYTES)) begin
            sum_a_in   = add_a;
            sum_b_in   = add_b;
            capture_en = 1'b1;
            pos_in     = pos_ff + PosW'(1);
         end else if (pos_ff == PosW'(PAYLOAD_BYTES + gpvt_pkg::HDR_BYTES)) begin
            rx_sum_a_in = b;
            pos_in      = pos_ff + PosW'(1);
         end else begin
            pos_in   = '0;
            evt.done = 1'b1;
         end
      end
   end

   // field capture at fixed payload offsets
   always_comb begin
      for (int i = 0; i < gpvt_pkg::DATE_BYTES; i++) begin
         date_in[i] = (capture_en && pos_ff == PosW'(DateFirst + i)) ? b : date_ff[i];
      end
      for (int i = 0; i < gpvt_pkg::POS_BYTES; i++) begin
         pos_byte_in[i] = (capture_en && pos_ff == PosW'(PosFirst + i)) ? b
                                                                          : pos_byte_ff[i];
      end
      valid_in = (capture_en && pos_ff == PosW'(gpvt_pkg::HDR_BYTES + gpvt_pkg::OFS_VALID))
                 ? b : valid_ff;
      flags_in = (capture_en && pos_ff == PosW'(gpvt_pkg::HDR_BYTES + gpvt_pkg::OFS_FLAGS))
                 ? b : flags_ff;
      sats_in  = (capture_en && pos_ff == PosW'(gpvt_pkg::HDR_BYTES + gpvt_pkg::OFS_SATS))
                 ? b : sats_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_a_ff    <= sum_a_in;
      sum_b_ff    <= sum_b_in;
      len_lo_ff   <= len_lo_in;
      rx_sum_a_ff <= rx_sum_a_in;
      date_ff     <= date_in;
      pos_byte_ff <= pos_byte_in;
      valid_ff    <= valid_in;
      flags_ff    <= flags_in;
      sats_ff     <= sats_in;
   end

   assign cap.year             = {date_ff[1], date_ff[0]};
   assign cap.month            = date_ff[2];
   assign cap.day              = date_ff[3];
   assign cap.hour             = date_ff[4];
   assign cap.minute           = date_ff[5];
   assign cap.second           = date_ff[6];
   assign cap.valid_byte       = valid_ff;
   assign cap.flags_byte       = flags_ff;
   assign cap.satellites       = sats_ff;
   assign cap.longitude        = {pos_byte_ff[3], pos_byte_ff[2],
                                  pos_byte_ff[1], pos_byte_ff[0]};
   assign cap.latitude         = {pos_byte_ff[7], pos_byte_ff[6],
                                  pos_byte_ff[5], pos_byte_ff[4]};
   assign cap.height_ellipsoid = {pos_byte_ff[11], pos_byte_ff[10],
                                  pos_byte_ff[9], pos_byte_ff[8]};
   assign cap.height_sea_level = {pos_byte_ff[15], pos_byte_ff[14],
                                  pos_byte_ff[13], pos_byte_ff[12]};
   assign cap.sum_a            = sum_a_ff;
   assign cap.sum_b            = sum_b_ff;
   assign cap.rx_sum_a         = rx_sum_a_ff;

   // position never runs past the second checksum byte
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosW'(PAYLOAD_BYTES + gpvt_pkg::HDR_BYTES + 1))
      else $error("byte position out of range");

   // a start word always lands on the high length byte next
   a_start: assert property (@(posedge clock) disable iff (reset)
      in_accept && in_word.frame_start |=> pos_ff == PosW'(1))
      else $error("frame start did not restart the message");

   // a finished or rejected message leaves the framer idle
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      evt.done || evt.len_err |=> pos_ff == '0)
      else $error("framer not idle after end of message");

endmodule

### sv/gpvt_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpvt_check
// field range, flag and checksum checks and result assembly
// ----------------------------------------------------------------------------
module gpvt_check (
   input  gpvt_pkg::cap_type cap,
   input  gpvt_pkg::evt_type evt,
   input  gpvt_pkg::cfg_type cfg,
   output logic              push,
   output gpvt_pkg::rsp_type result
);

   logic [3:0] status;

   // first failing check wins, checksum last
   always_comb begin
      if (cap.month == 8'd0 || cap.month > gpvt_pkg::MONTH_MAX) begin
         status = gpvt_pkg::ST_MONTH;
      end else if (cap.day == 8'd0 || cap.day > gpvt_pkg::DAY_MAX) begin
         status = gpvt_pkg::ST_DAY;
      end else if (cap.hour > gpvt_pkg::HOUR_MAX) begin
         status = gpvt_pkg::ST_HOUR;
      end else if (cap.minute > gpvt_pkg::MINUTE_MAX) begin
         status = gpvt_pkg::ST_MINUTE;
      end else if (cap.second > gpvt_pkg::SECOND_MAX) begin
         status = gpvt_pkg::ST_SECOND;
      end else if ((cap.valid_byte & cfg.valid_mask) == 8'd0) begin
         status = gpvt_pkg::ST_VALID;
      end else if ((cap.flags_byte & cfg.fix_mask) != 8'd0) begin
         status = gpvt_pkg::ST_FIX;
      end else if (cap.rx_sum_a != cap.sum_a || evt.ck_b != cap.sum_b) begin
         status = gpvt_pkg::ST_CHECKSUM;
      end else begin
         status = gpvt_pkg::ST_OK;
      end
   end

   assign push = evt.done || evt.len_err;

   always_comb begin
      if (evt.len_err) begin
         result        = '0;
         result.status = gpvt_pkg::ST_LENGTH;
      end else begin
         result.status           = status;
         result.year             = cap.year;
         result.month            = cap.month;
         result.day              = cap.day;
         result.hour             = cap.hour;
         result.minute           = cap.minute;
         result.second           = cap.second;
         result.satellites       = cap.satellites;
         result.longitude        = cap.longitude;
         result.latitude         = cap.latitude;
         result.height_ellipsoid = cap.height_ellipsoid;
         result.height_sea_level = cap.height_sea_level;
      end
   end

endmodule

### sv/gpvt_rsp_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpvt_rsp_buf
// two-entry result buffer between the checker and the result channel
// ----------------------------------------------------------------------------
module gpvt_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gpvt_pkg::rsp_type push_word,
   output logic              full,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gpvt_pkg::rsp_type rsp_payload
);

   gpvt_pkg::rsp_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid   = count_ff != 2'd0;
   assign full        = count_ff == 2'd2;
   assign pop         = rsp_valid && !rsp_stall;
   assign rsp_payload = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   // upstream must hold off while both entries are taken
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(full && push))
      else $error("result pushed into a full buffer");

   // count tracks the two pointers
   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff))
      else $error("buffer count out of step with pointers");

   // a push into an empty buffer is registered and raises rsp_valid
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      push && !rsp_valid |=> rsp_valid)
      else $error("pushed result not presented");

endmodule

### dv/pvt_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvt_report_checker
// watches the word, report and register ports of the pvt message parser,
// keeps its own copy of the framing state, the running checksum and the
// captured fields, and compares every report field by field with the one
// it predicts
// ----------------------------------------------------------------------------
module pvt_report_checker #(
   parameter int unsigned PAYLOAD_BYTES = gpvt_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  gpvt_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  gpvt_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_write_data,
   output int                fail_count,
   output int                pending,
   output int                reports_checked
);

   gpvt_pkg::cfg_type cfg;
   logic [7:0]        byte_pos;
   logic [7:0]        run_a;
   logic [7:0]        run_b;
   logic [7:0]        len_lo;
   logic [7:0]        ck_a_rx;
   logic [7:0]        date_cap [gpvt_pkg::DATE_BYTES];
   logic [7:0]        valid_cap;
   logic [7:0]        flags_cap;
   logic [7:0]        sats_cap;
   logic [31:0]       pos_cap [gpvt_pkg::POS_WORDS];

   gpvt_pkg::rsp_type predicted_reports [$];
   int                errors = 0;
   int                checked = 0;

   task automatic clear_model();
      int i;
      cfg       = '{msg_class: gpvt_pkg::CLASS_RST, msg_id: gpvt_pkg::ID_RST,
                    valid_mask: gpvt_pkg::VALID_MSK_RST, fix_mask: gpvt_pkg::FIX_MSK_RST};
      byte_pos  = '0;
      run_a     = '0;
      run_b     = '0;
      len_lo    = '0;
      ck_a_rx   = '0;
      valid_cap = '0;
      flags_cap = '0;
      sats_cap  = '0;
      for (i = 0; i < gpvt_pkg::DATE_BYTES; i++) date_cap[i] = '0;
      for (i = 0; i < gpvt_pkg::POS_WORDS; i++) pos_cap[i] = '0;
      predicted_reports.delete();
   endtask

   task automatic add_to_sum(input logic [7:0] b);
      run_a = run_a + b;
      run_b = run_b + run_a;
   endtask

   // first failing check wins, checksum last
   function automatic logic [3:0] grade_report(input logic [7:0] ck_b);
      if (date_cap[2] < 8'd1 || date_cap[2] > gpvt_pkg::MONTH_MAX) return gpvt_pkg::ST_MONTH;
      if (date_cap[3] < 8'd1 || date_cap[3] > gpvt_pkg::DAY_MAX) return gpvt_pkg::ST_DAY;
      if (date_cap[4] > gpvt_pkg::HOUR_MAX) return gpvt_pkg::ST_HOUR;
      if (date_cap[5] > gpvt_pkg::MINUTE_MAX) return gpvt_pkg::ST_MINUTE;
      if (date_cap[6] > gpvt_pkg::SECOND_MAX) return gpvt_pkg::ST_SECOND;
      if ((valid_cap & cfg.valid_mask) == 8'd0) return gpvt_pkg::ST_VALID;
      if ((flags_cap & cfg.fix_mask) != 8'd0) return gpvt_pkg::ST_FIX;
      if (ck_a_rx != run_a || ck_b != run_b) return gpvt_pkg::ST_CHECKSUM;
      return gpvt_pkg::ST_OK;
   endfunction

   task automatic capture_byte(input int unsigned idx, input logic [7:0] b);
      if (idx >= gpvt_pkg::OFS_DATE && idx < gpvt_pkg::OFS_DATE + gpvt_pkg::DATE_BYTES)
         date_cap[idx - gpvt_pkg::OFS_DATE] = b;
      else if (idx == gpvt_pkg::OFS_VALID)
         valid_cap = b;
      else if (idx == gpvt_pkg::OFS_FLAGS)
         flags_cap = b;
      else if (idx == gpvt_pkg::OFS_SATS)
         sats_cap = b;
      else if (idx >= gpvt_pkg::OFS_POS && idx < gpvt_pkg::OFS_POS + gpvt_pkg::POS_BYTES)
         pos_cap[(idx - gpvt_pkg::OFS_POS) / 4][((idx - gpvt_pkg::OFS_POS) % 4) * 8 +: 8] = b;
   endtask

   task automatic parse_word(input gpvt_pkg::req_type w);
      logic [15:0]       len;
      gpvt_pkg::rsp_type r;
      r = '0;
      if (w.frame_start) begin
         run_a = '0;
         run_b = '0;
         add_to_sum(cfg.msg_class);
         add_to_sum(cfg.msg_id);
         add_to_sum(w.data_byte);
         len_lo   = w.data_byte;
         byte_pos = 8'd1;
      end else if (byte_pos == 8'd0) begin
         // idle, word dropped
      end else if (byte_pos == 8'd1) begin
         len = {w.data_byte, len_lo};
         add_to_sum(w.data_byte);
         if (len != PAYLOAD_BYTES) begin
            byte_pos = 8'd0;
            r.status = gpvt_pkg::ST_LENGTH;
            predicted_reports.push_back(r);
         end else begin
            byte_pos = 8'd2;
         end
      end else if (byte_pos < PAYLOAD_BYTES + gpvt_pkg::HDR_BYTES) begin
         add_to_sum(w.data_byte);
         capture_byte(byte_pos - gpvt_pkg::HDR_BYTES, w.data_byte);
         byte_pos = byte_pos + 8'd1;
      end else if (byte_pos == PAYLOAD_BYTES + gpvt_pkg::HDR_BYTES) begin
         ck_a_rx  = w.data_byte;
         byte_pos = byte_pos + 8'd1;
      end else begin
         byte_pos           = 8'd0;
         r.status           = grade_report(w.data_byte);
         r.year             = {date_cap[1], date_cap[0]};
         r.month            = date_cap[2];
         r.day              = date_cap[3];
         r.hour             = date_cap[4];
         r.minute           = date_cap[5];
         r.second           = date_cap[6];
         r.satellites       = sats_cap;
         r.longitude        = pos_cap[0];
         r.latitude         = pos_cap[1];
         r.height_ellipsoid = pos_cap[2];
         r.height_sea_level = pos_cap[3];
         predicted_reports.push_back(r);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_report(input gpvt_pkg::rsp_type got);
      gpvt_pkg::rsp_type want;
      if (predicted_reports.size() == 0) begin
         $display("%0t ns: unexpected report, expected none, actual status %0d",
                  $time, got.status);
         errors++;
      end else begin
         want = predicted_reports.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("year", want.year, got.year);
         compare_field("month", want.month, got.month);
         compare_field("day", want.day, got.day);
         compare_field("hour", want.hour, got.hour);
         compare_field("minute", want.minute, got.minute);
         compare_field("second", want.second, got.second);
         compare_field("satellites", want.satellites, got.satellites);
         compare_field("longitude", want.longitude, got.longitude);
         compare_field("latitude", want.latitude, got.latitude);
         compare_field("height_ellipsoid", want.height_ellipsoid,
                       got.height_ellipsoid);
         compare_field("height_sea_level", want.height_sea_level,
                       got.height_sea_level);
      end
      checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               gpvt_pkg::REG_CLASS:     cfg.msg_class  = csr_write_data;
               gpvt_pkg::REG_ID:        cfg.msg_id     = csr_write_data;
               gpvt_pkg::REG_VALID_MSK: cfg.valid_mask = csr_write_data;
               gpvt_pkg::REG_FIX_MSK:   cfg.fix_mask   = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) parse_word(req_payload);
         if (rsp_valid && !rsp_stall) check_report(rsp_payload);
      end
      fail_count      <= errors;
      pending         <= predicted_reports.size();
      reports_checked <= checked;
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives framed pvt messages into the parser core: a directed set of edge
// values, every failing check, length errors and restarts, then random
// messages over several register settings, with random gaps on both sides
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned PAYLOAD_LEN = gpvt_pkg::PAYLOAD_BYTES_DEF;
   // two length bytes, payload, two checksum bytes
   localparam int unsigned FRAME_LEN   = PAYLOAD_LEN + 4;
   localparam int unsigned OFS_YEAR    = gpvt_pkg::OFS_DATE;
   localparam int unsigned OFS_MONTH   = gpvt_pkg::OFS_DATE + 2;
   localparam int unsigned OFS_DAY     = gpvt_pkg::OFS_DATE + 3;
   localparam int unsigned OFS_HOUR    = gpvt_pkg::OFS_DATE + 4;
   localparam int unsigned OFS_MINUTE  = gpvt_pkg::OFS_DATE + 5;
   localparam int unsigned OFS_SECOND  = gpvt_pkg::OFS_DATE + 6;
   localparam int unsigned OFS_VALID   = gpvt_pkg::OFS_VALID;
   localparam int unsigned OFS_FLAGS   = gpvt_pkg::OFS_FLAGS;
   localparam int unsigned OFS_SATS    = gpvt_pkg::OFS_SATS;
   localparam int unsigned OFS_POS     = gpvt_pkg::OFS_POS;
   localparam int unsigned HDR_BYTES   = gpvt_pkg::HDR_BYTES;
   localparam int          PHASES      = 4;
   localparam int          PHASE_WORDS = 80;
   localparam int          PHASE_REPORTS = 1;

   // kinds of message the generator builds
   typedef enum int {
      MSG_GOOD,
      MSG_RAW,
      MSG_BAD_MONTH,
      MSG_BAD_DAY,
      MSG_BAD_HOUR,
      MSG_BAD_MINUTE,
      MSG_BAD_SECOND,
      MSG_BAD_VALID,
      MSG_BAD_FIX,
      MSG_BAD_SUM,
      MSG_BAD_LENGTH,
      MSG_CUT
   } msg_kind_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   gpvt_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   gpvt_pkg::rsp_type rsp_payload;
   logic              csr_write_enable;
   logic [1:0]        csr_index;
   logic [7:0]        csr_write_data;

   int fail_count;
   int pending;
   int reports_checked;

   // stimulus side copy of the registers, needed to build valid checksums
   logic [7:0] cls;
   logic [7:0] mid;
   logic [7:0] vmask;
   logic [7:0] fmask;

   // payload of the message being built
   logic [7:0] pl [PAYLOAD_LEN];

   int words_sent    = 0;
   int messages_sent = 0;
   int reports_sent  = 0;
   int settings_used = 1;
   // set during the stretch where neither side idles
   bit no_idle = 1'b0;

   gnss_pvt_message_parser_core #(
      .PAYLOAD_BYTES(PAYLOAD_LEN)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   pvt_report_checker #(
      .PAYLOAD_BYTES(PAYLOAD_LEN)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .reports_checked (reports_checked)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // report side back-pressure on about ten percent of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(99, 0) < 10);
      end
   end

   // one random set bit of a nonzero mask
   function automatic logic [7:0] pick_bit(input logic [7:0] m);
      int b;
      do b = $urandom_range(7, 0); while (!m[b]);
      return 8'(1) << b;
   endfunction

   // present one word and hold it until accepted; may idle first
   task automatic send_word(input logic [7:0] b, input logic s);
      if (!no_idle && $urandom_range(99, 0) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: b, frame_start: s};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // one write per cycle; the caller drops the write enable after the last one
   task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         gpvt_pkg::REG_CLASS:     cls   = data;
         gpvt_pkg::REG_ID:        mid   = data;
         gpvt_pkg::REG_VALID_MSK: vmask = data;
         gpvt_pkg::REG_FIX_MSK:   fmask = data;
         default: ;
      endcase
   endtask

   // stop sending and wait until every predicted report has come out,
   // then wait longer for a frame that was cut and left no report
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // place a little-endian word in the payload
   task automatic put_word(input int unsigned ofs, input logic [31:0] w);
      int j;
      for (j = 0; j < 4; j++) pl[ofs + j] = w[8 * j +: 8];
   endtask

   // random payload, legal date and flags unless raw, then at most one field broken
   task automatic make_payload(input msg_kind_type kind);
      int i;
      for (i = 0; i < PAYLOAD_LEN; i++) pl[i] = 8'($urandom);
      if (kind != MSG_RAW) begin
         pl[OFS_MONTH]  = 8'($urandom_range(gpvt_pkg::MONTH_MAX, 1));
         pl[OFS_DAY]    = 8'($urandom_range(gpvt_pkg::DAY_MAX, 1));
         pl[OFS_HOUR]   = 8'($urandom_range(gpvt_pkg::HOUR_MAX, 0));
         pl[OFS_MINUTE] = 8'($urandom_range(gpvt_pkg::MINUTE_MAX, 0));
         pl[OFS_SECOND] = 8'($urandom_range(gpvt_pkg::SECOND_MAX, 0));
         if (vmask != 8'd0) pl[OFS_VALID] = pl[OFS_VALID] | pick_bit(vmask);
         pl[OFS_FLAGS] = pl[OFS_FLAGS] & ~fmask;
         case (kind)
            MSG_BAD_MONTH:
               pl[OFS_MONTH] = $urandom_range(1, 0) ? 8'd0 :
                               8'($urandom_range(255, gpvt_pkg::MONTH_MAX + 1));
            MSG_BAD_DAY:
               pl[OFS_DAY] = $urandom_range(1, 0) ? 8'd0 :
                             8'($urandom_range(255, gpvt_pkg::DAY_MAX + 1));
            MSG_BAD_HOUR:
               pl[OFS_HOUR] = 8'($urandom_range(255, gpvt_pkg::HOUR_MAX + 1));
            MSG_BAD_MINUTE:
               pl[OFS_MINUTE] = 8'($urandom_range(255, gpvt_pkg::MINUTE_MAX + 1));
            MSG_BAD_SECOND:
               pl[OFS_SECOND] = 8'($urandom_range(255, gpvt_pkg::SECOND_MAX + 1));
            MSG_BAD_VALID:  pl[OFS_VALID]  = pl[OFS_VALID] & ~vmask;
            MSG_BAD_FIX:
               if (fmask != 8'd0) pl[OFS_FLAGS] = pl[OFS_FLAGS] | pick_bit(fmask);
            default: ;
         endcase
      end
   endtask

   // frame the payload with a length and a checksum and send it; a wrong
   // length stops after the two length words, a cut stops after n words
   task automatic send_frame(input int unsigned cut, input logic [15:0] len,
                             input logic [7:0] flip_a, input logic [7:0] flip_b);
      logic [7:0]  frame [FRAME_LEN];
      logic [7:0]  ck_a;
      logic [7:0]  ck_b;
      int unsigned i;
      int unsigned n;
      frame[0] = len[7:0];
      frame[1] = len[15:8];
      for (i = 0; i < PAYLOAD_LEN; i++) frame[HDR_BYTES + i] = pl[i];
      // fletcher sum seeded with class and id, over length and payload
      ck_a = cls;
      ck_b = cls;
      ck_a = ck_a + mid;
      ck_b = ck_b + ck_a;
      for (i = 0; i < PAYLOAD_LEN + HDR_BYTES; i++) begin
         ck_a = ck_a + frame[i];
         ck_b = ck_b + ck_a;
      end
      frame[FRAME_LEN - 2] = ck_a ^ flip_a;
      frame[FRAME_LEN - 1] = ck_b ^ flip_b;
      n = (len != PAYLOAD_LEN) ? HDR_BYTES : cut;
      for (i = 0; i < n; i++) send_word(frame[i], i == 0);
      if (len != PAYLOAD_LEN || cut == FRAME_LEN) reports_sent++;
      messages_sent++;
   endtask

   // half clean messages, the rest raw, broken in one field, cut or mis-sized
   task automatic random_message();
      int           r;
      logic [15:0]  len;
      logic [7:0]   fa;
      logic [7:0]   fb;
      msg_kind_type k;
      r   = $urandom_range(99, 0);
      fa  = 8'd0;
      fb  = 8'd0;
      len = 16'(PAYLOAD_LEN);
      if (r < 50)      k = MSG_GOOD;
      else if (r < 58) k = MSG_RAW;
      else if (r < 80) k = msg_kind_type'($urandom_range(int'(MSG_BAD_SUM),
                                                          int'(MSG_BAD_MONTH)));
      else if (r < 90) k = MSG_BAD_LENGTH;
      else             k = MSG_CUT;
      make_payload(k);
      if (k == MSG_BAD_SUM) begin
         case ($urandom_range(2, 0))
            0: fa = 8'($urandom_range(255, 1));
            1: fb = 8'($urandom_range(255, 1));
            default: begin
               fa = 8'($urandom_range(255, 1));
               fb = 8'($urandom_range(255, 1));
            end
         endcase
      end
      if (k == MSG_BAD_LENGTH) begin
         // right low byte with a nonzero high byte, or anything else
         if ($urandom_range(1, 0)) len = {8'($urandom_range(255, 1)), 8'(PAYLOAD_LEN)};
         else do len = 16'($urandom); while (len == PAYLOAD_LEN);
      end
      send_frame(k == MSG_CUT ? $urandom_range(FRAME_LEN - 1, 1) : FRAME_LEN,
                 len, fa, fb);
      // now and then a few stray words between frames
      if ($urandom_range(9, 0) == 0)
         repeat ($urandom_range(3, 1)) send_word(8'($urandom), 1'b0);
   endtask

   initial begin
      int          k;
      int          p;
      int          w0;
      int          r0;
      logic [15:0] bad_lens [5];

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_index        = gpvt_pkg::REG_CLASS;
      csr_write_data   = 8'd0;
      cls              = gpvt_pkg::CLASS_RST;
      mid              = gpvt_pkg::ID_RST;
      vmask            = gpvt_pkg::VALID_MSK_RST;
      fmask            = gpvt_pkg::FIX_MSK_RST;
      bad_lens = '{16'h0000, 16'hffff, 16'(PAYLOAD_LEN - 1), 16'(PAYLOAD_LEN + 1),
                   16'(PAYLOAD_LEN + 256)};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---------------- directed part, reset register values ----------------
      // stray words with no frame open are dropped
      send_word(8'h00, 1'b0);
      send_word(8'hff, 1'b0);

      // lowest legal date and time, most negative position words
      make_payload(MSG_GOOD);
      pl[OFS_YEAR]     = 8'h00;
      pl[OFS_YEAR + 1] = 8'h00;
      pl[OFS_MONTH]    = 8'd1;
      pl[OFS_DAY]      = 8'd1;
      pl[OFS_HOUR]     = 8'd0;
      pl[OFS_MINUTE]   = 8'd0;
      pl[OFS_SECOND]   = 8'd0;
      pl[OFS_SATS]     = 8'h00;
      for (k = 0; k < gpvt_pkg::POS_WORDS; k++) put_word(OFS_POS + 4 * k, 32'h8000_0000);
      send_frame(FRAME_LEN, 16'(PAYLOAD_LEN), 8'd0, 8'd0);

      // highest legal date and time, most positive position words
      make_payload(MSG_GOOD);
      pl[OFS_YEAR]     = 8'hff;
      pl[OFS_YEAR + 1] = 8'hff;
      pl[OFS_MONTH]    = gpvt_pkg::MONTH_MAX;
      pl[OFS_DAY]      = gpvt_pkg::DAY_MAX;
      pl[OFS_HOUR]     = gpvt_pkg::HOUR_MAX;
      pl[OFS_MINUTE]   = gpvt_pkg::MINUTE_MAX;
      pl[OFS_SECOND]   = gpvt_pkg::SECOND_MAX;
      pl[OFS_VALID]    = 8'hff;
      pl[OFS_FLAGS]    = 8'h00;
      pl[OFS_SATS]     = 8'hff;
      for (k = 0; k < gpvt_pkg::POS_WORDS; k++) put_word(OFS_POS + 4 * k, 32'h7fff_ffff);
      send_frame(FRAME_LEN, 16'(PAYLOAD_LEN), 8'd0, 8'd0);

      // each range and validity check failing on its own; the fix mask is still zero
      for (k = MSG_BAD_MONTH; k <= MSG_BAD_FIX; k++) begin
         make_payload(msg_kind_type'(k));
         send_frame(FRAME_LEN, 16'(PAYLOAD_LEN), 8'd0, 8'd0);
      end

      // one step past the legal range
      make_payload(MSG_GOOD);
      pl[OFS_MONTH] = gpvt_pkg::MONTH_MAX + 8'd1;
      send_frame(FRAME_LEN, 16'(PAYLOAD_LEN), 8'd0, 8'd0);
      make_payload(MSG_GOOD);
      pl[OFS_DAY] = 8'd0;
      send_frame(FRAME_LEN, 16'(PAYLOAD_LEN), 8'd0, 8'd0);
      make_payload(MSG_GOOD);
      pl[OFS_SECOND] = gpvt_pkg::SECOND_MAX + 8'd1;
      send_frame(FRAME_LEN, 16'(PAYLOAD_LEN), 8'd0, 8'd0);

      // first and second checksum byte wrong
      make_payload(MSG_GOOD);
      send_frame(FRAME_LEN, 16'(PAYLOAD_LEN), 8'h01, 8'h00);
      make_payload(MSG_GOOD);
      send_frame(FRAME_LEN, 16'(PAYLOAD_LEN), 8'h00, 8'h80);

      // length errors report at once with all other fields zero
      for (k = 0; k < 5; k++) send_frame(FRAME_LEN, bad_lens[k], 8'd0, 8'd0);

      // restart: a new frame start abandons the open message, mid payload
      // and again right after the first checksum word
      make_payload(MSG_GOOD);
      send_frame(50, 16'(PAYLOAD_LEN), 8'd0, 8'd0);
      make_payload(MSG_GOOD);
      send_frame(FRAME_LEN - 1, 16'(PAYLOAD_LEN), 8'd0, 8'd0);
      // two frame starts in a row
      send_word(8'(PAYLOAD_LEN), 1'b1);
      make_payload(MSG_GOOD);
      send_frame(FRAME_LEN, 16'(PAYLOAD_LEN), 8'd0, 8'd0);

      // sender holds off until every report is out
      drain();

      // ---------------- random part over several register settings ----------
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               // zero seeds, every fix bit fatal
               write_reg(gpvt_pkg::REG_CLASS, 8'h00);
               write_reg(gpvt_pkg::REG_ID, 8'h00);
               write_reg(gpvt_pkg::REG_VALID_MSK, 8'hff);
               write_reg(gpvt_pkg::REG_FIX_MSK, 8'hff);
            end
            1: begin
               // full seeds, validity can never pass
               write_reg(gpvt_pkg::REG_CLASS, 8'hff);
               write_reg(gpvt_pkg::REG_ID, 8'hff);
               write_reg(gpvt_pkg::REG_VALID_MSK, 8'h00);
               write_reg(gpvt_pkg::REG_FIX_MSK, 8'h00);
            end
            2: begin
               // reset values again, and the stretch with no idling
               write_reg(gpvt_pkg::REG_CLASS, gpvt_pkg::CLASS_RST);
               write_reg(gpvt_pkg::REG_ID, gpvt_pkg::ID_RST);
               write_reg(gpvt_pkg::REG_VALID_MSK, gpvt_pkg::VALID_MSK_RST);
               write_reg(gpvt_pkg::REG_FIX_MSK, gpvt_pkg::FIX_MSK_RST);
               no_idle = 1'b1;
            end
            default: begin
               write_reg(gpvt_pkg::REG_CLASS, 8'($urandom));
               write_reg(gpvt_pkg::REG_ID, 8'($urandom));
               write_reg(gpvt_pkg::REG_VALID_MSK, 8'($urandom));
               write_reg(gpvt_pkg::REG_FIX_MSK, 8'($urandom));
            end
         endcase
         csr_write_enable <= 1'b0;
         settings_used++;
         w0 = words_sent;
         r0 = reports_sent;
         while (words_sent - w0 < PHASE_WORDS || reports_sent - r0 < PHASE_REPORTS)
            random_message();
         drain();
         no_idle = 1'b0;
      end

      // extra wait for anything still in flight
      repeat (10) @(posedge clock);

      $display("summary: %0d words in %0d messages under %0d register settings",
               words_sent, messages_sent, settings_used);
      $display("summary: %0d reports checked, %0d field mismatches",
               reports_checked, fail_count);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         if (pending != 0)
            $display("%0t ns: %0d predicted reports never came out", $time, pending);
         $display("status: fail");
      end
      $finish;
   end

   // hard stop far beyond the slowest correct run
   initial begin
      #5_000_000;
      $display("%0t ns: timeout with %0d reports outstanding", $time, pending);
      $display("status: fail");
      $finish;
   end

endmodule
